>>> rtl/core/bfl_pkg.sv
// Shared types, constants and lookup tables for the barometric forecast letter block.
package bfl_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE_TOP    = 2'd0;
    localparam logic [1:0] CFG_SCALE_BOTTOM = 2'd1;
    localparam logic [1:0] CFG_NORTH        = 2'd2;

    // Divider geometry: 33-bit dividend magnitude, 18-bit divisor
    localparam int NUM_W      = 33;
    localparam int DEN_W      = 18;
    localparam int DIV_STAGES = NUM_W;

    // Q8 / Q16 constants
    localparam logic signed [16:0] Q8_SPAN    = 17'sd25600;
    localparam logic signed [23:0] Q8_BASE    = 24'sd243200;
    localparam logic signed [13:0] Q8_SUMMER  = 14'sd819;
    localparam logic [13:0]        RISE_COEF  = 14'd11403;
    localparam logic [13:0]        FALL_COEF  = 14'd10178;
    localparam logic [13:0]        STEADY_COEF = 14'd15165;
    localparam logic signed [24:0] RISE_REF   = 25'sd264038;
    localparam logic signed [24:0] FALL_REF   = 25'sd263667;
    localparam logic signed [24:0] STEADY_REF = 25'sd263887;
    localparam logic signed [39:0] ROUND_HALF = 40'sd8388608;

    typedef enum logic [1:0] {
        TREND_STEADY = 2'd0,
        TREND_RISE   = 2'd1,
        TREND_FALL   = 2'd2
    } t_trend;

    // Wind offsets per sector, Q8 hPa
    localparam logic signed [12:0] WIND_Q8 [16] = '{
        13'sd1331,  13'sd1075,  13'sd819,   13'sd269,
        -13'sd282,  -13'sd806,  -13'sd1331, -13'sd2138,
        -13'sd2944, -13'sd2406, -13'sd1869, -13'sd1344,
        -13'sd819,  -13'sd294,  13'sd230,   13'sd781
    };

    localparam int RISE_LEN   = 14;
    localparam int FALL_LEN   = 10;
    localparam int STEADY_LEN = 17;

    localparam logic [4:0] RISE_TAB [RISE_LEN] = '{
        5'd0, 5'd1, 5'd1, 5'd2, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12, 5'd12, 5'd16,
        5'd19, 5'd24
    };
    localparam logic [4:0] FALL_TAB [FALL_LEN] = '{
        5'd1, 5'd3, 5'd7, 5'd14, 5'd17, 5'd20, 5'd21, 5'd23, 5'd23, 5'd25
    };
    localparam logic [4:0] STEADY_TAB [STEADY_LEN] = '{
        5'd0, 5'd1, 5'd1, 5'd1, 5'd4, 5'd10, 5'd13, 5'd13, 5'd15, 5'd15, 5'd18,
        5'd22, 5'd22, 5'd23, 5'd23, 5'd23, 5'd25
    };

    // Sideband that rides alongside the divider
    typedef struct packed {
        logic                neg;
        logic                zero;
        t_trend              trend;
        logic signed [13:0]  adj;
    } t_side;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div_req;

    typedef struct packed {
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
        t_side            side;
    } t_div_rsp;

    // Clamp the rounded index to the chosen table and look the letter up
    function automatic logic [4:0] bfl_letter(input t_trend trend,
                                              input logic signed [39:0] prod);
        logic [14:0] idx;
        logic [4:0]  letter;
        begin
            idx    = prod[38:24];
            letter = 5'd0;
            case (trend)
                TREND_RISE: begin
                    if (prod[39])
                        letter = RISE_TAB[0];
                    else if (idx > 15'(RISE_LEN - 1))
                        letter = RISE_TAB[RISE_LEN-1];
                    else
                        letter = RISE_TAB[idx[3:0]];
                end
                TREND_FALL: begin
                    if (prod[39])
                        letter = FALL_TAB[0];
                    else if (idx > 15'(FALL_LEN - 1))
                        letter = FALL_TAB[FALL_LEN-1];
                    else
                        letter = FALL_TAB[idx[3:0]];
                end
                TREND_STEADY: begin
                    if (prod[39])
                        letter = STEADY_TAB[0];
                    else if (idx > 15'(STEADY_LEN - 1))
                        letter = STEADY_TAB[STEADY_LEN-1];
                    else
                        letter = STEADY_TAB[idx[4:0]];
                end
                default: letter = 5'd0;
            endcase
            return letter;
        end
    endfunction

endpackage

>>> rtl/core/bfl_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a travelling sideband.
module bfl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic               i_req_valid,
    input  bfl_pkg::t_div_req  i_req,
    output logic               o_rsp_valid,
    output bfl_pkg::t_div_rsp  o_rsp
);
    import bfl_pkg::*;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div_stage;

    function automatic t_div_stage div_step(input t_div_stage s);
        logic [DEN_W:0] trial;
        logic           take;
        t_div_stage     o;
        begin
            o     = s;
            trial = {s.rem, s.num[NUM_W-1]};
            take  = (trial >= {1'b0, s.den});
            o.rem = take ? DEN_W'(trial - {1'b0, s.den}) : trial[DEN_W-1:0];
            o.quo = {s.quo[NUM_W-2:0], take};
            o.num = {s.num[NUM_W-2:0], 1'b0};
            return o;
        end
    endfunction

    t_div_stage               r_stage [DIV_STAGES];
    logic [DIV_STAGES-1:0]    r_valid;
    t_div_stage               src     [DIV_STAGES];

    assign src[0] = '{num: i_req.num, quo: '0, rem: '0, den: i_req.den, side: i_req.side};

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_src
        assign src[k] = r_stage[k-1];
    end

    // Payload: advance every stage together
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_stage[k] <= div_step(src[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_advance) begin
            r_valid <= {r_valid[DIV_STAGES-2:0], i_req_valid};
        end
    end

    assign o_rsp_valid = r_valid[DIV_STAGES-1];
    assign o_rsp       = '{quo:  r_stage[DIV_STAGES-1].quo,
                           rem:  r_stage[DIV_STAGES-1].rem,
                           side: r_stage[DIV_STAGES-1].side};

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (r_stage[DIV_STAGES-1].den != '0))
            |-> (r_stage[DIV_STAGES-1].rem < r_stage[DIV_STAGES-1].den))
        else $error("divider remainder not below divisor");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_valid))
        else $error("divider valid bits moved while held");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_req_valid) |=> r_valid[0])
        else $error("divider dropped an entering request");

endmodule

>>> rtl/core/barometric_forecast_letter.sv
// Top level of the barometric forecast letter block: pipelined forecaster datapath.
//
// Takes one reading (pressure, month, wind, trend) per unstalled clock and returns one
// forecast letter, 0 = A to 25 = Z. The reading passes 39 register stages before its
// letter is presented at the output, where it is taken on an edge at which i_stall is low.
// Readings are independent and one is accepted every cycle while the output is not
// stalled; the depth is set by the normalising divider, which resolves one of 33 quotient
// bits per stage. A stall on the output freezes the whole pipeline, so o_stall is raised
// exactly while a finished letter waits at the output and i_stall is high. Write the
// scale and hemisphere registers only while no reading is in flight.
module barometric_forecast_letter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [16:0]        i_station_pressure,
    input  logic [3:0]         i_month_number,
    input  logic [3:0]         i_wind_heading,
    input  logic               i_wind_calm,
    input  logic signed [8:0]  i_pressure_change,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_forecast_letter
);
    import bfl_pkg::*;

    // ---------------------------------------------------------------- configuration
    logic [16:0] r_scale_top;
    logic [16:0] r_scale_bottom;
    logic        r_north;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_top    <= 17'd105000;
            r_scale_bottom <= 17'd95000;
            r_north        <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE_TOP:    r_scale_top    <= i_cfg_data;
                CFG_SCALE_BOTTOM: r_scale_bottom <= i_cfg_data;
                CFG_NORTH:        r_north        <= i_cfg_data[0];
                default:          ; // drop writes to unused indexes
            endcase
        end
    end

    // The whole pipeline moves together; hold everything while the output is
    // occupied and stalled.
    logic advance;
    assign advance = !o_valid || !i_stall;
    assign o_stall = !advance;

    // ---------------------------------------------------------------- stage 1
    // Signed span and offset from the bottom of the scale, folded so that the
    // divisor is always a magnitude; wind and summer offsets resolved here.
    logic signed [17:0] span;
    logic               span_neg;
    logic signed [17:0] span_abs;
    logic signed [17:0] offs;
    logic [3:0]         heading;
    logic               summer;
    logic               rising;
    logic               falling;
    logic signed [13:0] wind_adj;
    logic signed [13:0] shift_adj;
    t_trend             trend;
    t_side              n_s1_side;

    assign span     = $signed({1'b0, r_scale_top}) - $signed({1'b0, r_scale_bottom});
    assign span_neg = span[17];
    assign span_abs = span_neg ? -span : span;

    always_comb begin
        offs = $signed({1'b0, i_station_pressure}) - $signed({1'b0, r_scale_bottom});
        if (span_neg)
            offs = -offs;
        // turn the heading half a circle south of the equator
        heading   = r_north ? i_wind_heading : 4'(i_wind_heading + 4'd8);
        summer    = (r_north == (i_month_number inside {[4'd4:4'd9]}));
        rising    = (i_pressure_change > 9'sd0);
        falling   = i_pressure_change[8];
        wind_adj  = i_wind_calm ? 14'sd0 : 14'(WIND_Q8[heading]);
        shift_adj = 14'sd0;
        if (rising) begin
            trend = TREND_RISE;
            if (summer)
                shift_adj = Q8_SUMMER;
        end else if (falling) begin
            trend = TREND_FALL;
            if (summer)
                shift_adj = -Q8_SUMMER;
        end else begin
            trend = TREND_STEADY;
        end
        n_s1_side = '{neg: 1'b0, zero: (span == 18'sd0), trend: trend,
                      adj: 14'(wind_adj + shift_adj)};
    end

    logic               r_s1_valid;
    logic signed [17:0] r_s1_offs;
    logic [16:0]        r_s1_den;
    t_side              r_s1_side;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_offs <= offs;
            r_s1_den  <= span_abs[16:0];
            r_s1_side <= n_s1_side;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // Dividend 2*num + den for round half up, split into sign and magnitude.
    logic signed [33:0] num;
    logic signed [35:0] dividend;
    logic signed [35:0] dividend_abs;
    t_div_req           n_s2_req;

    assign num          = 34'(r_s1_offs) * 34'(Q8_SPAN);
    assign dividend     = (36'(num) <<< 1) + $signed(36'({1'b0, r_s1_den}));
    assign dividend_abs = dividend[35] ? -dividend : dividend;

    always_comb begin
        n_s2_req          = '{num: dividend_abs[NUM_W-1:0], den: {r_s1_den, 1'b0},
                              side: r_s1_side};
        n_s2_req.side.neg = dividend[35];
    end

    logic     r_s2_valid;
    t_div_req r_s2_req;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_req <= n_s2_req;
        end
    end

    // ---------------------------------------------------------------- divider
    logic     div_valid;
    t_div_rsp div_rsp;

    bfl_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_req_valid (r_s2_valid),
        .i_req       (r_s2_req),
        .o_rsp_valid (div_valid),
        .o_rsp       (div_rsp)
    );

    // ---------------------------------------------------------------- stage A
    // Floor the signed quotient and saturate it: anything beyond 2^20 lands far
    // outside every table and clamps the same way.
    logic [20:0]        mag_sat;
    logic [21:0]        mag_ceil;
    logic signed [22:0] quo_s;
    logic signed [23:0] n_sa_p;

    always_comb begin
        mag_sat  = (|div_rsp.quo[NUM_W-1:20]) ? 21'h100000 : {1'b0, div_rsp.quo[19:0]};
        mag_ceil = 22'(mag_sat) + 22'(div_rsp.side.neg && (div_rsp.rem != '0));
        quo_s    = $signed({1'b0, mag_ceil});
        if (div_rsp.side.neg)
            quo_s = -quo_s;
        if (div_rsp.side.zero)
            quo_s = 23'sd0;
        n_sa_p = Q8_BASE + 24'(quo_s) + 24'(div_rsp.side.adj);
    end

    logic               r_sa_valid;
    logic signed [23:0] r_sa_p;
    t_trend             r_sa_trend;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sa_p     <= n_sa_p;
            r_sa_trend <= div_rsp.side.trend;
        end
    end

    // ---------------------------------------------------------------- stage B
    // Pick reference and coefficient, take the distance below the reference.
    logic signed [24:0] ref_q8;
    logic [13:0]        coef;

    always_comb begin
        case (r_sa_trend)
            TREND_RISE: begin
                ref_q8 = RISE_REF;
                coef   = RISE_COEF;
            end
            TREND_FALL: begin
                ref_q8 = FALL_REF;
                coef   = FALL_COEF;
            end
            default: begin
                ref_q8 = STEADY_REF;
                coef   = STEADY_COEF;
            end
        endcase
    end

    logic               r_sb_valid;
    logic signed [24:0] r_sb_dist;
    logic [13:0]        r_sb_coef;
    t_trend             r_sb_trend;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sb_dist  <= ref_q8 - 25'(r_sa_p);
            r_sb_coef  <= coef;
            r_sb_trend <= r_sa_trend;
        end
    end

    // ---------------------------------------------------------------- stage C
    // Q16 x Q8 product plus half an index step.
    logic signed [39:0] r_sc_prod;
    logic               r_sc_valid;
    t_trend             r_sc_trend;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sc_prod  <= 40'($signed({1'b0, r_sb_coef})) * 40'(r_sb_dist) + ROUND_HALF;
            r_sc_trend <= r_sb_trend;
        end
    end

    // ---------------------------------------------------------------- output
    logic       r_out_valid;
    logic [4:0] r_out_letter;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_letter <= bfl_letter(r_sc_trend, r_sc_prod);
        end
    end

    // Valid bits travel with the data and reset clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_sa_valid  <= 1'b0;
            r_sb_valid  <= 1'b0;
            r_sc_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_sa_valid  <= div_valid;
            r_sb_valid  <= r_sa_valid;
            r_sc_valid  <= r_sb_valid;
            r_out_valid <= r_sc_valid;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_forecast_letter = r_out_letter;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_forecast_letter <= 5'd25))
        else $error("forecast letter out of range");

    a_last_stage_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sc_valid && advance) |=> o_valid)
        else $error("result lost between last stage and output");

endmodule
